[design/gsm_pkg.sv]
// Shared types and constants for the gated stereo-to-mono mixer.
// No dependencies; imported by gsm_ctrl, gsm_dp and the top level.
`default_nettype none

package gsm_pkg;

  localparam int SAMPLE_W = 16;   // audio sample width
  localparam int GAIN_W   = 15;   // gate gain / target width
  localparam int OGAIN_W  = 4;    // output gain register width

  localparam logic [OGAIN_W-1:0]  OGAIN_RST  = 4'd6;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 16'h7fff;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = 16'h8000;

  // Gate full scale (unity gain) and its width
  localparam int              FS_W       = 16;
  localparam longint unsigned FULL_SCALE = 64'd32767;

  // Magnitude widths along the frame path
  localparam int AMAG_W = SAMPLE_W;
  localparam int MMAG_W = AMAG_W + OGAIN_W;
  localparam int PMAG_W = MMAG_W + GAIN_W;

  // Quotient clips high when it reaches 32768, low when it reaches 32769
  localparam longint unsigned SAT_POS = 64'd32768 * FULL_SCALE;
  localparam longint unsigned SAT_NEG = 64'd32769 * FULL_SCALE;

  // Unsaturated dividends stay below SAT_NEG
  localparam int              DIV_N_W  = $clog2(SAT_NEG);
  localparam int              RECIP_SH = DIV_N_W + 1;
  localparam longint unsigned RECIP    = (64'd1 << RECIP_SH) / FULL_SCALE;
  localparam int              RECIP_W  = $clog2(RECIP + 1);
  localparam int              Q_W      = SAMPLE_W + 1;

  typedef enum logic [1:0] {
    REQ_FRAME = 2'd0,
    REQ_SET   = 2'd1,
    REQ_CLEAR = 2'd2
  } gsm_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_F_MUL,
    ST_F_DIV,
    ST_F_FIN,
    ST_S_DIV,
    ST_S_FIN
  } gsm_state_t;

  typedef struct packed {
    logic load_frame;  // capture frame, mix, advance gate
    logic load_set;    // capture target, form delta
    logic clear;       // zero gate state
    logic mul;         // gate multiply
    logic div;         // reciprocal multiply, clip detect
    logic fin;         // correction, load output register
    logic sdiv;        // ramp step reciprocal multiply
    logic sfin;        // ramp step correction and store
  } gsm_cmd_t;

endpackage

`default_nettype wire

[design/gsm_ctrl.sv]
// Controller FSM for the gated stereo-to-mono mixer.
// Depends on gsm_pkg; drives gsm_cmd_t commands into gsm_dp.
`default_nettype none

module gsm_ctrl import gsm_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [1:0]       in_req_type,
  output logic             in_stall,
  input  logic             out_busy,
  output gsm_cmd_t         cmd
);

  gsm_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (gsm_req_t'(in_req_type))
            REQ_FRAME: begin
              cmd.load_frame = 1'b1;
              state_nxt      = ST_F_MUL;
            end
            REQ_SET: begin
              cmd.load_set = 1'b1;
              state_nxt    = ST_S_DIV;
            end
            REQ_CLEAR: begin
              cmd.clear = 1'b1;
            end
            default: ;  // unused request type: dropped
          endcase
        end
      end
      ST_F_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_F_DIV;
      end
      ST_F_DIV: begin
        cmd.div   = 1'b1;
        state_nxt = ST_F_FIN;
      end
      ST_F_FIN: begin
        if (!out_busy) begin
          cmd.fin   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_S_DIV: begin
        cmd.sdiv  = 1'b1;
        state_nxt = ST_S_FIN;
      end
      ST_S_FIN: begin
        cmd.sfin  = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[design/gsm_dp.sv]
// Datapath for the gated stereo-to-mono mixer: mix, gate ramp, divide, saturate.
// Depends on gsm_pkg; sequenced by gsm_ctrl through gsm_cmd_t.
`default_nettype none

module gsm_dp import gsm_pkg::*; #(
  parameter int RAMP_SAMPLES = 1024
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [OGAIN_W-1:0]         cfg_wdata,
  input  logic signed [SAMPLE_W-1:0] in_left_sample,
  input  logic signed [SAMPLE_W-1:0] in_right_sample,
  input  logic [GAIN_W-1:0]          in_target_gain,
  input  gsm_cmd_t                   cmd,
  output logic                       out_busy,
  input  logic                       out_stall,
  output logic                       out_valid,
  output logic signed [SAMPLE_W-1:0] out_mono_sample,
  output logic                       out_clipped,
  output logic [GAIN_W-1:0]          out_gate_level
);

  localparam int RS_W      = $clog2(RAMP_SAMPLES + 1);
  localparam int GAIN_MAX  = (1 << GAIN_W) - 1;
  localparam int STEP_MAG  = (GAIN_MAX / RAMP_SAMPLES > 0) ? GAIN_MAX / RAMP_SAMPLES : 1;
  localparam int STEP_W    = $clog2(STEP_MAG + 1) + 1;
  localparam int RRECIP_SH = GAIN_W + 1;
  localparam int RRECIP    = (1 << RRECIP_SH) / RAMP_SAMPLES;
  localparam int RRECIP_W  = $clog2(RRECIP + 1);
  localparam int FPROD_W   = DIV_N_W + RECIP_W;
  localparam int FQD_W     = Q_W + FS_W;
  localparam int SPROD_W   = GAIN_W + RRECIP_W;
  localparam int SQD_W     = GAIN_W + RS_W;

  // control / architectural state
  logic [OGAIN_W-1:0]       ogain_r;
  logic [GAIN_W-1:0]        gate_gain_r;
  logic [GAIN_W-1:0]        gate_target_r;
  logic signed [STEP_W-1:0] gate_step_r;
  logic                     out_valid_r;

  // payload registers
  logic                     sign_r;
  logic [MMAG_W-1:0]        mmag_r;
  logic [PMAG_W-1:0]        pmag_r;
  logic [Q_W-1:0]           q0_r;
  logic                     clip_hi_r;
  logic                     clip_lo_r;
  logic                     dsign_r;
  logic [GAIN_W-1:0]        dmag_r;
  logic [GAIN_W-1:0]        sq0_r;
  logic [SAMPLE_W-1:0]      out_mono_r;
  logic                     out_clip_r;
  logic [GAIN_W-1:0]        out_level_r;

  // combinational
  logic [SAMPLE_W:0]        sum17;
  logic [SAMPLE_W:0]        adj17;
  logic [SAMPLE_W-1:0]      avg;
  logic [AMAG_W-1:0]        amag;
  logic [MMAG_W-1:0]        mmag_nxt;
  logic signed [GAIN_W+1:0] gsum;
  logic signed [GAIN_W+1:0] tgt_s;
  logic                     rising;
  logic [GAIN_W-1:0]        gain_adv;
  logic [GAIN_W:0]          delta;
  logic [GAIN_W:0]          dabs;
  logic [FPROD_W-1:0]       fprod;
  logic [FQD_W-1:0]         fqd;
  logic [FQD_W-1:0]         frem;
  logic [Q_W-1:0]           qfin;
  logic [Q_W-1:0]           qneg;
  logic [SAMPLE_W-1:0]      mono_nxt;
  logic [SPROD_W-1:0]       sprod;
  logic [SQD_W-1:0]         sqd;
  logic [SQD_W-1:0]         srem;
  logic [GAIN_W-1:0]        sq;
  logic [GAIN_W-1:0]        smag;
  logic [STEP_W-1:0]        smag_w;
  logic [STEP_W-1:0]        step_nxt;

  // mix: average truncated toward zero, then sign/magnitude times output gain
  always_comb begin
    sum17    = {in_left_sample[SAMPLE_W-1], in_left_sample}
             + {in_right_sample[SAMPLE_W-1], in_right_sample};
    adj17    = sum17 + {{SAMPLE_W{1'b0}}, sum17[SAMPLE_W]};
    avg      = adj17[SAMPLE_W:1];
    amag     = avg[SAMPLE_W-1] ? (~avg + 1'b1) : avg;
    mmag_nxt = MMAG_W'(amag) * MMAG_W'(ogain_r);
  end

  // gate advance, clamped at target
  always_comb begin
    gsum   = $signed({2'b00, gate_gain_r})
           + $signed({{(GAIN_W + 2 - STEP_W){gate_step_r[STEP_W-1]}}, gate_step_r});
    tgt_s  = $signed({2'b00, gate_target_r});
    rising = !gate_step_r[STEP_W-1] && (gate_step_r != '0);
    if (gate_gain_r == gate_target_r) begin
      gain_adv = gate_gain_r;
    end else if ((rising && gsum > tgt_s) || (!rising && gsum < tgt_s)) begin
      gain_adv = gate_target_r;
    end else begin
      gain_adv = gsum[GAIN_W-1:0];
    end
  end

  // set target: delta, then step = delta / RAMP_SAMPLES by reciprocal
  always_comb begin
    delta    = {1'b0, in_target_gain} - {1'b0, gate_gain_r};
    dabs     = delta[GAIN_W] ? (~delta + 1'b1) : delta;
    sprod    = SPROD_W'(dmag_r) * SPROD_W'(RRECIP);
    sqd      = SQD_W'(sq0_r) * SQD_W'(RAMP_SAMPLES);
    srem     = SQD_W'(dmag_r) - sqd;
    sq       = sq0_r + GAIN_W'(srem >= SQD_W'(RAMP_SAMPLES));
    smag     = (sq == '0 && dmag_r != '0) ? GAIN_W'(1) : sq;
    smag_w   = STEP_W'(smag);
    step_nxt = dsign_r ? (~smag_w + 1'b1) : smag_w;
  end

  // frame divide by full scale: reciprocal estimate, one-step correction
  always_comb begin
    fprod = FPROD_W'(pmag_r[DIV_N_W-1:0]) * FPROD_W'(RECIP);
    fqd   = FQD_W'(q0_r) * FQD_W'(FULL_SCALE);
    frem  = FQD_W'(pmag_r[DIV_N_W-1:0]) - fqd;
    qfin  = q0_r + Q_W'(frem >= FQD_W'(FULL_SCALE));
    qneg  = ~qfin + 1'b1;
    if (clip_hi_r) begin
      mono_nxt = SAMPLE_MAX;
    end else if (clip_lo_r) begin
      mono_nxt = SAMPLE_MIN;
    end else if (sign_r) begin
      mono_nxt = qneg[SAMPLE_W-1:0];
    end else begin
      mono_nxt = qfin[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ogain_r       <= OGAIN_RST;
      gate_gain_r   <= '0;
      gate_target_r <= '0;
      gate_step_r   <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        ogain_r <= cfg_wdata;
      end
      if (cmd.clear) begin
        gate_gain_r   <= '0;
        gate_target_r <= '0;
        gate_step_r   <= '0;
      end
      if (cmd.load_frame) begin
        gate_gain_r <= gain_adv;
      end
      if (cmd.load_set) begin
        gate_target_r <= in_target_gain;
      end
      if (cmd.sfin) begin
        gate_step_r <= $signed(step_nxt);
      end
      if (cmd.fin) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_frame) begin
      sign_r <= avg[SAMPLE_W-1];
      mmag_r <= mmag_nxt;
    end
    if (cmd.mul) begin
      pmag_r <= PMAG_W'(mmag_r) * PMAG_W'(gate_gain_r);
    end
    if (cmd.div) begin
      q0_r      <= Q_W'(fprod >> RECIP_SH);
      clip_hi_r <= !sign_r && (pmag_r >= PMAG_W'(SAT_POS));
      clip_lo_r <= sign_r && (pmag_r >= PMAG_W'(SAT_NEG));
    end
    if (cmd.fin) begin
      out_mono_r  <= mono_nxt;
      out_clip_r  <= clip_hi_r || clip_lo_r;
      out_level_r <= gate_gain_r;
    end
    if (cmd.load_set) begin
      dsign_r <= delta[GAIN_W];
      dmag_r  <= dabs[GAIN_W-1:0];
    end
    if (cmd.sdiv) begin
      sq0_r <= GAIN_W'(sprod >> RRECIP_SH);
    end
  end

  assign out_busy        = out_valid_r && out_stall;
  assign out_valid       = out_valid_r;
  assign out_mono_sample = $signed(out_mono_r);
  assign out_clipped     = out_clip_r;
  assign out_gate_level  = out_level_r;

endmodule

`default_nettype wire

[design/gated_stereo_to_mono_mixer.sv]
// Gated stereo-to-mono mixer, top level. Depends on gsm_pkg, gsm_ctrl, gsm_dp.
// An audio frame holds the datapath through accept/mix, gate multiply, reciprocal multiply
// and correct/saturate; the last step waits while out_stall keeps the output register full,
// then loads it. A set-target request runs the step divide (reciprocal multiply, then
// correction and store); clear and unused codes are done when accepted.
// Reset (rst_n low, synchronous): gate gain/target/step zero, output gain 6, output empty.
`default_nettype none

module gated_stereo_to_mono_mixer import gsm_pkg::*; #(
  parameter int RAMP_SAMPLES = 1024
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // configuration: output gain
  input  logic                       cfg_we,
  input  logic [OGAIN_W-1:0]         cfg_wdata,
  // request channel
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 in_req_type,
  input  logic signed [SAMPLE_W-1:0] in_left_sample,
  input  logic signed [SAMPLE_W-1:0] in_right_sample,
  input  logic [GAIN_W-1:0]          in_target_gain,
  // result channel
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [SAMPLE_W-1:0] out_mono_sample,
  output logic                       out_clipped,
  output logic [GAIN_W-1:0]          out_gate_level
);

  gsm_cmd_t cmd;
  logic     out_busy;

  // Controller: takes one request at a time, steps the datapath, and holds
  // the last frame step until the output register can take the result.
  gsm_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_req_type),
    .in_stall    (in_stall),
    .out_busy    (out_busy),
    .cmd         (cmd)
  );

  // Datapath: gate state, output gain, mixing arithmetic and the output
  // register. Division by full scale and by the ramp length uses a constant
  // reciprocal multiply followed by a single compare-and-increment.
  gsm_dp #(
    .RAMP_SAMPLES (RAMP_SAMPLES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_left_sample  (in_left_sample),
    .in_right_sample (in_right_sample),
    .in_target_gain  (in_target_gain),
    .cmd             (cmd),
    .out_busy        (out_busy),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_mono_sample (out_mono_sample),
    .out_clipped     (out_clipped),
    .out_gate_level  (out_gate_level)
  );

  // Clipped results sit exactly on a rail.
  a_clip_rail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_clipped) |->
      (out_mono_sample == $signed(SAMPLE_MAX) || out_mono_sample == $signed(SAMPLE_MIN)))
    else $error("clipped result not at a rail");

  // A result is only loaded from the final frame step, where requests are held off.
  a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("output loaded while controller idle");

  // Non-frame requests never create a result.
  a_cmd_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_req_type != REQ_FRAME && !out_valid) |=> !out_valid)
    else $error("command request produced a result");

endmodule

`default_nettype wire
